[rtl/core/ipv4hv_pkg.sv]
package ipv4hv_pkg;

    // Verdict codes, first failing check wins
    typedef enum logic [3:0] {
        RSN_OK       = 4'd0,
        RSN_SHORT    = 4'd1,
        RSN_VERSION  = 4'd2,
        RSN_IHL      = 4'd3,
        RSN_TOTLEN   = 4'd4,
        RSN_TTL      = 4'd5,
        RSN_PROTO    = 4'd6,
        RSN_CKSUM    = 4'd7,
        RSN_TCPTRUNC = 4'd8,
        RSN_TCPOFF   = 4'd9,
        RSN_UDPTRUNC = 4'd10,
        RSN_UDPLEN   = 4'd11
    } reason_t;

    // Header layout and limits
    localparam logic [16:0] MIN_HDR_BYTES = 17'd20;
    localparam logic [16:0] UDP_HDR_BYTES = 17'd8;
    localparam logic [16:0] CNT_SAT       = 17'h10000;
    localparam logic [3:0]  IP_VERSION    = 4'd4;

    // Byte offsets from the start of the IPv4 header
    localparam logic [16:0] OFS_TOTLEN_HI = 17'd2;
    localparam logic [16:0] OFS_TOTLEN_LO = 17'd3;
    localparam logic [16:0] OFS_TTL       = 17'd8;
    localparam logic [16:0] OFS_PROTO     = 17'd9;
    localparam logic [16:0] OFS_CKSUM_HI  = 17'd10;
    localparam logic [16:0] OFS_CKSUM_LO  = 17'd11;

    // Byte offsets from the end of the IPv4 header
    localparam logic [16:0] OFS_UDPLEN_HI = 17'd4;
    localparam logic [16:0] OFS_UDPLEN_LO = 17'd5;
    localparam logic [16:0] OFS_TCPOFF    = 17'd12;

    // Protocol numbers
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_IGMP  = 8'd2;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_IPV6  = 8'd41;
    localparam logic [7:0] PROTO_GRE   = 8'd47;
    localparam logic [7:0] PROTO_ESP   = 8'd50;
    localparam logic [7:0] PROTO_AH    = 8'd51;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Captured packet summary handed from front to back
    typedef struct packed {
        logic [16:0] size;
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [15:0] declared_sum;
        logic [15:0] running_sum;
        logic [3:0]  tcp_offset;
        logic [15:0] udp_length;
    } pkt_summary_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic proto_known(input logic [7:0] p);
        logic known;
        known = (p == PROTO_ICMP) || (p == PROTO_IGMP) || (p == PROTO_TCP) ||
                (p == PROTO_UDP) || (p == PROTO_IPV6) || (p == PROTO_GRE) ||
                (p == PROTO_ESP) || (p == PROTO_AH) || (p == PROTO_ICMP6);
        return known;
    endfunction

endpackage

[rtl/core/ipv4hv_front.sv]
module ipv4hv_front
    import ipv4hv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          in_valid,
    output logic          in_stall,
    input  queue_status_t q_status,
    output logic          push,
    output pkt_summary_t  push_data
);

    logic [16:0] count_reg, count_next, count_upd;
    logic [3:0]  version_reg, version_next, version_upd;
    logic [3:0]  hw_reg, hw_next, hw_upd;
    logic [15:0] totlen_reg, totlen_next, totlen_upd;
    logic [7:0]  ttl_reg, ttl_next, ttl_upd;
    logic [7:0]  proto_reg, proto_next, proto_upd;
    logic [15:0] decl_reg, decl_next, decl_upd;
    logic [15:0] sum_reg, sum_next, sum_upd;
    logic [7:0]  hold_reg, hold_next, hold_upd;
    logic [3:0]  tcpoff_reg, tcpoff_next, tcpoff_upd;
    logic [15:0] udplen_reg, udplen_next, udplen_upd;

    logic        fire;
    logic [16:0] hlen;
    logic [16:0] word_sum;

    assign in_stall = q_status.full;
    assign fire     = in_valid && !in_stall;
    assign push     = fire && last_byte;

    // Field capture and header sum for the current byte
    always_comb
    begin
        version_upd = version_reg;
        hw_upd      = hw_reg;
        totlen_upd  = totlen_reg;
        ttl_upd     = ttl_reg;
        proto_upd   = proto_reg;
        decl_upd    = decl_reg;
        sum_upd     = sum_reg;
        hold_upd    = hold_reg;
        tcpoff_upd  = tcpoff_reg;
        udplen_upd  = udplen_reg;
        word_sum    = {1'b0, sum_reg} + {1'b0, hold_reg, data_byte};

        if (count_reg == 17'd0)
        begin
            version_upd = data_byte[7:4];
            hw_upd      = data_byte[3:0];
        end
        hlen = {11'd0, hw_upd, 2'b00};

        if (count_reg == OFS_TOTLEN_HI) totlen_upd[15:8] = data_byte;
        if (count_reg == OFS_TOTLEN_LO) totlen_upd[7:0]  = data_byte;
        if (count_reg == OFS_TTL)       ttl_upd          = data_byte;
        if (count_reg == OFS_PROTO)     proto_upd        = data_byte;
        if (count_reg == OFS_CKSUM_HI)  decl_upd[15:8]   = data_byte;
        if (count_reg == OFS_CKSUM_LO)  decl_upd[7:0]    = data_byte;

        // ones' complement sum, checksum word skipped, folded every add
        if ((count_reg < hlen) && (count_reg != OFS_CKSUM_HI) &&
            (count_reg != OFS_CKSUM_LO))
        begin
            if (!count_reg[0])
                hold_upd = data_byte;
            else
                sum_upd = word_sum[15:0] + {15'd0, word_sum[16]};
        end

        // transport header fields just past the IPv4 header
        if (count_reg == hlen + OFS_TCPOFF)    tcpoff_upd       = data_byte[7:4];
        if (count_reg == hlen + OFS_UDPLEN_HI) udplen_upd[15:8] = data_byte;
        if (count_reg == hlen + OFS_UDPLEN_LO) udplen_upd[7:0]  = data_byte;

        // saturating byte counter
        count_upd = (count_reg == CNT_SAT) ? count_reg : count_reg + 17'd1;
    end

    // Summary of the finished packet
    always_comb
    begin
        push_data.size         = count_upd;
        push_data.version      = version_upd;
        push_data.header_words = hw_upd;
        push_data.total_length = totlen_upd;
        push_data.ttl          = ttl_upd;
        push_data.protocol     = proto_upd;
        push_data.declared_sum = decl_upd;
        push_data.running_sum  = sum_upd;
        push_data.tcp_offset   = tcpoff_upd;
        push_data.udp_length   = udplen_upd;
    end

    // Hold, advance, or clear after the last byte
    always_comb
    begin
        count_next   = count_reg;
        version_next = version_reg;
        hw_next      = hw_reg;
        totlen_next  = totlen_reg;
        ttl_next     = ttl_reg;
        proto_next   = proto_reg;
        decl_next    = decl_reg;
        sum_next     = sum_reg;
        hold_next    = hold_reg;
        tcpoff_next  = tcpoff_reg;
        udplen_next  = udplen_reg;
        if (fire && last_byte)
        begin
            count_next   = '0;
            version_next = '0;
            hw_next      = '0;
            totlen_next  = '0;
            ttl_next     = '0;
            proto_next   = '0;
            decl_next    = '0;
            sum_next     = '0;
            hold_next    = '0;
            tcpoff_next  = '0;
            udplen_next  = '0;
        end
        else if (fire)
        begin
            count_next   = count_upd;
            version_next = version_upd;
            hw_next      = hw_upd;
            totlen_next  = totlen_upd;
            ttl_next     = ttl_upd;
            proto_next   = proto_upd;
            decl_next    = decl_upd;
            sum_next     = sum_upd;
            hold_next    = hold_upd;
            tcpoff_next  = tcpoff_upd;
            udplen_next  = udplen_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            version_reg <= '0;
            hw_reg      <= '0;
            totlen_reg  <= '0;
            ttl_reg     <= '0;
            proto_reg   <= '0;
            decl_reg    <= '0;
            sum_reg     <= '0;
            hold_reg    <= '0;
            tcpoff_reg  <= '0;
            udplen_reg  <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            version_reg <= version_next;
            hw_reg      <= hw_next;
            totlen_reg  <= totlen_next;
            ttl_reg     <= ttl_next;
            proto_reg   <= proto_next;
            decl_reg    <= decl_next;
            sum_reg     <= sum_next;
            hold_reg    <= hold_next;
            tcpoff_reg  <= tcpoff_next;
            udplen_reg  <= udplen_next;
        end
    end

endmodule

[rtl/core/ipv4hv_queue.sv]
module ipv4hv_queue
    import ipv4hv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pkt_summary_t  push_data,
    input  logic          pop,
    output pkt_summary_t  head,
    output queue_status_t status
);

    pkt_summary_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/core/ipv4hv_back.sv]
module ipv4hv_back
    import ipv4hv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pkt_summary_t  head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          flagged,
    output logic [3:0]    reason_code,
    output logic          out_valid,
    input  logic          out_stall
);

    logic    valid_reg, valid_next;
    logic    flagged_reg;
    reason_t reason_reg;
    reason_t verdict;

    logic [16:0] hlen;
    logic [16:0] totlen_ext;
    logic [16:0] tcp_bytes;
    logic [16:0] udp_ext;

    assign pop         = !q_status.empty && (!valid_reg || !out_stall);
    assign out_valid   = valid_reg;
    assign flagged     = flagged_reg;
    assign reason_code = reason_reg;

    // Checks in priority order on the queue head
    always_comb
    begin
        hlen       = {11'd0, head.header_words, 2'b00};
        totlen_ext = {1'b0, head.total_length};
        tcp_bytes  = {11'd0, head.tcp_offset, 2'b00};
        udp_ext    = {1'b0, head.udp_length};
        verdict    = RSN_OK;
        priority if (head.size < MIN_HDR_BYTES)
            verdict = RSN_SHORT;
        else if (head.version != IP_VERSION)
            verdict = RSN_VERSION;
        else if ((hlen < MIN_HDR_BYTES) || (hlen > head.size))
            verdict = RSN_IHL;
        else if ((totlen_ext < hlen) || (totlen_ext != head.size))
            verdict = RSN_TOTLEN;
        else if (head.ttl == 8'd0)
            verdict = RSN_TTL;
        else if (!proto_known(head.protocol))
            verdict = RSN_PROTO;
        else if (head.declared_sum != ~head.running_sum)
            verdict = RSN_CKSUM;
        else if (head.protocol == PROTO_TCP)
        begin
            if (head.size < hlen + MIN_HDR_BYTES)
                verdict = RSN_TCPTRUNC;
            else if ((tcp_bytes < MIN_HDR_BYTES) || (hlen + tcp_bytes > head.size))
                verdict = RSN_TCPOFF;
        end
        else if (head.protocol == PROTO_UDP)
        begin
            if (head.size < hlen + UDP_HDR_BYTES)
                verdict = RSN_UDPTRUNC;
            else if ((udp_ext < UDP_HDR_BYTES) || (hlen + udp_ext != head.size))
                verdict = RSN_UDPLEN;
        end
        else
            verdict = RSN_OK;
    end

    // Output register valid
    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flagged_reg <= (verdict != RSN_OK);
            reason_reg  <= verdict;
        end
    end

endmodule

[rtl/core/ipv4_header_validator_unit.sv]
// Channel   Signals                           Direction  Transfer
// input     data_byte, last_byte              in         in_valid && !in_stall
// result    flagged, reason_code              out        out_valid && !out_stall
//
// One byte per cycle is taken while in_stall is low; a packet's verdict passes
// from its last byte through the summary queue, then the verdict register.
// The sustained rate is set by the front capture stage, one byte per clock while in_stall is low.
// rst_n clears the byte counter, captured fields, queue and output valid.
// in_stall rises only when the two-entry summary queue is full, which happens
// only when finished packets keep arriving while the result side is stalled.
module ipv4_header_validator_unit
    import ipv4hv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       flagged,
    output logic [3:0] reason_code,
    output logic       out_valid,
    input  logic       out_stall
);

    queue_status_t q_status;
    pkt_summary_t  push_data;
    pkt_summary_t  head;
    logic          push;
    logic          pop;

    // Byte capture and header sum
    ipv4hv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Packet summary queue
    ipv4hv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Verdict and result register
    ipv4hv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .flagged     (flagged),
        .reason_code (reason_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

`ifndef SYNTHESIS
    // queue cannot be empty and full at once
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("summary queue reports empty and full");

    // a finished packet always lands in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=> !q_status.empty)
        else $error("packet summary lost");

    // flag agrees with the reason code
    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flagged == (reason_code != RSN_OK)))
        else $error("flag and reason code disagree");

    // a pop always refills the result register
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped summary produced no result");
`endif

endmodule
